>>> hdl/lz_token_bit_encoder_macros.svh
// Assertion macros for the LZ token bit encoder; they sample on clk and are disabled in rst.
`ifndef LZ_TOKEN_BIT_ENCODER_MACROS_SVH
`define LZ_TOKEN_BIT_ENCODER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define LZTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz_token_bit_encoder: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define LZTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz_token_bit_encoder: next-cycle check failed");

`endif

>>> hdl/lzte_pkg.sv
// Types and constants shared by the LZ token bit encoder and its channel interfaces.
`default_nettype none
package lzte_pkg;

  typedef enum logic [2:0] {
    CT_LITERAL   = 3'd0,
    CT_LEN1      = 3'd1,
    CT_LEN2      = 3'd2,
    CT_LEN3_NEAR = 3'd3,
    CT_LEN3_FAR  = 3'd4,
    CT_VAR_NEAR  = 3'd5,
    CT_VAR_FAR   = 3'd6
  } code_type_t;

  typedef struct packed {
    logic [7:0]         literal_byte;
    logic signed [15:0] displacement;
    logic [8:0]         match_length;
  } token_t;

  typedef struct packed {
    logic        code_valid;
    code_type_t  code_type;
    logic [4:0]  bit_size;
    logic [31:0] prefix_bits;
    logic [4:0]  prefix_count;
    logic [7:0]  byte_value;
    logic        has_byte;
  } code_t;

  // Fixed prefix patterns, left-aligned
  localparam logic [31:0] PREFIX_LITERAL = 32'h8000_0000;
  localparam logic [31:0] PREFIX_LEN2    = 32'h2000_0000;
  localparam logic [31:0] PREFIX_LEN3    = 32'h4000_0000;
  localparam logic [31:0] PREFIX_LEN3_FAR = 32'h5000_0000;
  localparam logic [31:0] PREFIX_VAR     = 32'h6000_0000;

  // Displacement range limits
  localparam logic signed [15:0] DISP_LEN1_MIN = -16'sd8;
  localparam logic signed [15:0] DISP_NEAR_MIN = -16'sd256;
  localparam logic signed [15:0] DISP_FAR_MAX  = -16'sd257;
  localparam logic signed [15:0] DISP_FAR_MIN  = -16'sd4352;

  // Offset added before taking the high displacement nibble
  localparam logic [11:0] HI_NIBBLE_BIAS = 12'h100;

  // Code sizes of the fixed classes
  localparam logic [4:0] SIZE_LITERAL   = 5'd9;
  localparam logic [4:0] SIZE_LEN1      = 5'd6;
  localparam logic [4:0] SIZE_LEN2      = 5'd11;
  localparam logic [4:0] SIZE_LEN3_NEAR = 5'd12;
  localparam logic [4:0] SIZE_LEN3_FAR  = 5'd16;
  localparam logic [4:0] BYTE_BITS      = 5'd8;

endpackage
`default_nettype wire

>>> hdl/lzte_if.sv
// Valid/ready channel interfaces for LZ tokens in and coded tokens out.
`default_nettype none
interface lzte_token_if;
  import lzte_pkg::*;
  logic   valid;
  logic   ready;
  token_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lzte_code_if;
  import lzte_pkg::*;
  logic  valid;
  logic  ready;
  code_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/lz_token_bit_encoder.sv
// LZ token bit encoder: classifies one token per cycle and builds its prefix bit pattern.
// A token accepted on tok is held in an input register; classification, gamma length
// coding and prefix shifting then load the result register that drives code, and its
// result is valid on code once it is in that register. One token is accepted every
// cycle as long as code is taken; the input and result registers form a two-deep
// pipeline, so a stalled result still lets one more token enter. Tokens that cannot be
// coded give a result with code_valid low and all other fields zero. There is no state
// besides the pipeline.
`default_nettype none
module lz_token_bit_encoder (
  input  wire           clk,
  input  wire           rst,
  lzte_token_if.sink    tok,
  lzte_code_if.source   code
);
  import lzte_pkg::*;

  `include "lz_token_bit_encoder_macros.svh"

  logic   s1_valid;
  token_t s1_tok;
  logic   out_valid;
  code_t  out_res;
  code_t  res_next;
  logic   s1_ready;
  logic   out_ready;

  // Pipeline handshake
  assign out_ready  = !out_valid || code.ready;
  assign s1_ready   = !s1_valid || out_ready;
  assign tok.ready  = s1_ready;
  assign code.valid = out_valid;
  assign code.payload = out_res;

  // Advance pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= tok.valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (s1_ready && tok.valid) begin
      s1_tok <= tok.payload;
    end
    if (out_ready && s1_valid) begin
      out_res <= res_next;
    end
  end

  logic signed [15:0] d;
  logic [8:0]  len;
  logic        is_literal;
  logic        in_len1;
  logic        in_near;
  logic        in_far;
  logic [7:0]  lowb;
  logic [11:0] hi_sum;
  logic [3:0]  hi4;
  logic [6:0]  v;
  logic [2:0]  b;
  logic [7:0]  onehot;
  logic [7:0]  gamma;
  logic [4:0]  shift_near;
  logic [4:0]  shift_far;
  logic [31:0] var_near_bits;
  logic [31:0] var_far_bits;
  logic [4:0]  size_near;
  logic [4:0]  size_far;

  // Decode displacement ranges
  assign d          = s1_tok.displacement;
  assign len        = s1_tok.match_length;
  assign is_literal = (d == 16'sd0) || (len == 9'd0);
  assign in_len1    = (d < 16'sd0) && (d >= DISP_LEN1_MIN);
  assign in_near    = (d < 16'sd0) && (d >= DISP_NEAR_MIN);
  assign in_far     = (d <= DISP_FAR_MAX) && (d >= DISP_FAR_MIN);
  assign lowb       = d[7:0];
  assign hi_sum     = d[11:0] + HI_NIBBLE_BIAS;
  assign hi4        = hi_sum[11:8];

  // Find bit count of (len-2)/2 for the gamma length field
  assign v = 7'(len[7:1] - 7'd1);
  always_comb begin
    priority if (v[6]) b = 3'd7;
    else if (v[5])     b = 3'd6;
    else if (v[4])     b = 3'd5;
    else if (v[3])     b = 3'd4;
    else if (v[2])     b = 3'd3;
    else if (v[1])     b = 3'd2;
    else if (v[0])     b = 3'd1;
    else               b = 3'd0;
  end

  // Build gamma field and place it after the variable-length class marker
  assign onehot     = 8'd1 << b;
  assign gamma      = ((onehot - 8'd1) & (len[7:0] - onehot - 8'd2)) | onehot;
  assign shift_near = 5'd28 - {1'b0, b, 1'b0};
  assign shift_far  = 5'd24 - {1'b0, b, 1'b0};
  assign var_near_bits = PREFIX_VAR | ({23'd0, gamma, 1'b0} << shift_near);
  assign var_far_bits  = PREFIX_VAR | ({19'd0, gamma, 1'b1, hi4} << shift_far);
  assign size_near  = {1'b0, b, 1'b0} + SIZE_LEN3_NEAR;
  assign size_far   = {1'b0, b, 1'b0} + SIZE_LEN3_FAR;

  // Select class and result fields
  always_comb begin
    res_next = '0;
    priority if (is_literal) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_LITERAL;
      res_next.bit_size     = SIZE_LITERAL;
      res_next.prefix_bits  = PREFIX_LITERAL;
      res_next.prefix_count = 5'd1;
      res_next.byte_value   = s1_tok.literal_byte;
      res_next.has_byte     = 1'b1;
    end else if (len == 9'd1 && in_len1) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_LEN1;
      res_next.bit_size     = SIZE_LEN1;
      res_next.prefix_bits  = {3'b000, d[2:0], 26'd0};
      res_next.prefix_count = 5'd6;
    end else if (len == 9'd2 && in_near) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_LEN2;
      res_next.bit_size     = SIZE_LEN2;
      res_next.prefix_bits  = PREFIX_LEN2;
      res_next.prefix_count = 5'd3;
      res_next.byte_value   = lowb;
      res_next.has_byte     = 1'b1;
    end else if (len == 9'd3 && in_near) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_LEN3_NEAR;
      res_next.bit_size     = SIZE_LEN3_NEAR;
      res_next.prefix_bits  = PREFIX_LEN3;
      res_next.prefix_count = 5'd4;
      res_next.byte_value   = lowb;
      res_next.has_byte     = 1'b1;
    end else if (len == 9'd3 && in_far) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_LEN3_FAR;
      res_next.bit_size     = SIZE_LEN3_FAR;
      res_next.prefix_bits  = PREFIX_LEN3_FAR | {4'd0, hi4, 24'd0};
      res_next.prefix_count = 5'd8;
      res_next.byte_value   = lowb;
      res_next.has_byte     = 1'b1;
    end else if (len >= 9'd4 && !len[8] && in_near) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_VAR_NEAR;
      res_next.bit_size     = size_near;
      res_next.prefix_bits  = var_near_bits;
      res_next.prefix_count = size_near - BYTE_BITS;
      res_next.byte_value   = lowb;
      res_next.has_byte     = 1'b1;
    end else if (len >= 9'd4 && !len[8] && in_far) begin
      res_next.code_valid   = 1'b1;
      res_next.code_type    = CT_VAR_FAR;
      res_next.bit_size     = size_far;
      res_next.prefix_bits  = var_far_bits;
      res_next.prefix_count = size_far - BYTE_BITS;
      res_next.byte_value   = lowb;
      res_next.has_byte     = 1'b1;
    end else begin
      res_next = '0;
    end
  end

  // Checks on pipeline flow and result consistency
  `LZTE_ASSERT_NEXT(a_accept_fills_s1, tok.valid && tok.ready, s1_valid)
  `LZTE_ASSERT_IMPL(a_invalid_is_zero, code.valid && !code.payload.code_valid,
    code.payload.bit_size == 5'd0 && code.payload.prefix_count == 5'd0)
  `LZTE_ASSERT_IMPL(a_size_sums, code.valid && code.payload.code_valid,
    code.payload.bit_size == code.payload.prefix_count +
      (code.payload.has_byte ? BYTE_BITS : 5'd0))
  `LZTE_ASSERT_IMPL(a_no_byte_len1,
    code.valid && code.payload.code_valid && !code.payload.has_byte,
    code.payload.code_type == CT_LEN1)

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the LZ token bit encoder: directed table, random tokens, output check.
module tb_top;
  import lzte_pkg::*;

  localparam int RANDOM_ITEMS  = 1426;
  localparam int HOLD_CYCLES   = 48;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam code_t NO_CODE    = '0;

  // One row of the directed table; the code is used only where known is set
  typedef struct {
    token_t tok;
    bit     known;
    code_t  code;
  } plan_row_t;

  typedef struct {
    bit    known;
    code_t code;
  } typed_note_t;

  logic clk;
  logic rst;

  lzte_token_if tok_ch ();
  lzte_code_if  code_ch ();

  lz_token_bit_encoder DUT (
    .clk  (clk),
    .rst  (rst),
    .tok  (tok_ch),
    .code (code_ch)
  );

  plan_row_t   directed_rows[$];
  typed_note_t typed_notes[$];
  code_t       expected_codes[$];

  int  tokens_sent;
  int  codes_seen;
  int  errors;
  int  idle_cycles;
  bit  hold_request;
  bit  hold_active;

  typed_note_t note;
  code_t       want;

  // Predict the coded form of one token
  function automatic code_t encode_token(token_t t);
    code_t       c;
    int          d;
    int          b;
    logic [31:0] du;
    logic [31:0] lowb;
    logic [31:0] hi4;
    logic [31:0] v;
    logic [31:0] p;
    logic [31:0] len;
    c    = NO_CODE;
    d    = $signed(t.displacement);
    du   = d;
    len  = {23'd0, t.match_length};
    lowb = du & 32'h0000_00FF;
    hi4  = (du + 32'h0000_0100) & 32'h0000_0F00;
    if (d == 0 || len == 0) begin
      c = code_t'{1'b1, CT_LITERAL, SIZE_LITERAL, PREFIX_LITERAL, 5'd1, t.literal_byte, 1'b1};
    end else if (len == 1) begin
      if (d >= -8 && d <= -1)
        c = code_t'{1'b1, CT_LEN1, SIZE_LEN1, (du & 32'd7) << 26, 5'd6, 8'h00, 1'b0};
    end else if (len == 2) begin
      if (d >= -256 && d <= -1)
        c = code_t'{1'b1, CT_LEN2, SIZE_LEN2, PREFIX_LEN2, 5'd3, lowb[7:0], 1'b1};
    end else if (len == 3) begin
      if (d >= -256 && d <= -1)
        c = code_t'{1'b1, CT_LEN3_NEAR, SIZE_LEN3_NEAR, PREFIX_LEN3, 5'd4, lowb[7:0], 1'b1};
      else if (d >= -4352 && d <= -257)
        c = code_t'{1'b1, CT_LEN3_FAR, SIZE_LEN3_FAR, PREFIX_LEN3_FAR | (hi4 << 16), 5'd8,
                    lowb[7:0], 1'b1};
    end else if (len <= 255) begin
      if (d >= -4352 && d <= -1) begin
        // gamma-style length: b is the bit count of (len-2)/2
        v = (len - 32'd2) >> 1;
        b = 0;
        while (v != 0) begin
          b++;
          v = v >> 1;
        end
        p = ((32'd1 << b) - 32'd1) & (len - (32'd1 << b) - 32'd2);
        p = p | (32'd1 << b);
        c.code_valid = 1'b1;
        c.byte_value = lowb[7:0];
        c.has_byte   = 1'b1;
        if (d >= -256) begin
          c.code_type   = CT_VAR_NEAR;
          c.bit_size    = 5'(2 * b + 12);
          p = p << 1;
          c.prefix_bits = PREFIX_VAR | (p << (28 - 2 * b));
        end else begin
          c.code_type   = CT_VAR_FAR;
          c.bit_size    = 5'(2 * b + 16);
          p = (p << 1) | 32'd1;
          p = (p << 4) | (hi4 >> 8);
          c.prefix_bits = PREFIX_VAR | (p << (24 - 2 * b));
        end
        c.prefix_count = c.bit_size - BYTE_BITS;
      end
    end
    return c;
  endfunction

  function automatic token_t make_tok(int lit, int disp, int len);
    token_t t;
    t.literal_byte = lit[7:0];
    t.displacement = disp[15:0];
    t.match_length = len[8:0];
    return t;
  endfunction

  function automatic void add_row(token_t t, bit known, code_t c);
    plan_row_t r;
    r.tok   = t;
    r.known = known;
    r.code  = c;
    directed_rows.push_back(r);
  endfunction

  // Report one field that differs; return 1 on mismatch
  function automatic bit field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random token: mostly codable classes, some broken combinations and noise
  function automatic token_t random_token();
    int lit;
    int r;
    int top;
    lit = $urandom_range(0, 255);
    r   = $urandom_range(0, 99);
    top = (1 << $urandom_range(3, 8)) - 1;
    if (r < 10) return make_tok(lit, 0, $urandom_range(0, 511));
    if (r < 14) return make_tok(lit, $urandom_range(0, 65535), 0);
    if (r < 24) return make_tok(lit, -$urandom_range(1, 8), 1);
    if (r < 34) return make_tok(lit, -$urandom_range(1, 256), 2);
    if (r < 44) return make_tok(lit, -$urandom_range(1, 256), 3);
    if (r < 54) return make_tok(lit, -$urandom_range(257, 4352), 3);
    if (r < 67) return make_tok(lit, -$urandom_range(1, 256), $urandom_range(4, top));
    if (r < 80) return make_tok(lit, -$urandom_range(257, 4352), $urandom_range(4, top));
    if (r < 88) begin
      case ($urandom_range(0, 4))
        0: return make_tok(lit, -$urandom_range(9, 300), 1);
        1: return make_tok(lit, -$urandom_range(257, 32768), 2);
        2: return make_tok(lit, -$urandom_range(4353, 32768), $urandom_range(3, 255));
        3: return make_tok(lit, $urandom_range(1, 32767), $urandom_range(1, 255));
        default: return make_tok(lit, -$urandom_range(1, 4352), $urandom_range(256, 511));
      endcase
    end
    return make_tok(lit, $urandom_range(0, 65535), $urandom_range(0, 511));
  endfunction

  // Offer one item and hold it until accepted
  task automatic drive_token(token_t t, bit known, code_t c);
    typed_note_t n;
    n.known = known;
    n.code  = c;
    typed_notes.push_back(n);
    tok_ch.valid   <= 1'b1;
    tok_ch.payload <= t;
    @(posedge clk);
    while (!tok_ch.ready) @(posedge clk);
    tokens_sent++;
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      tok_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every accepted item has come out
  task automatic wait_drained();
    while (codes_seen < tokens_sent) begin
      tok_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, no-stall stretches, one long hold-off on request
  initial begin
    int run;
    int stall;
    int r;
    code_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        code_ch.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
        hold_request = 1'b0;
      end
      code_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70) run = $urandom_range(1, 4);
      else if (r < 95) run = $urandom_range(5, 20);
      else run = $urandom_range(40, 120);
      for (int i = 0; i < run && !hold_request; i++) @(posedge clk);
      stall = pick_gap();
      if (stall > 0 && !hold_request) begin
        code_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check results against the oldest expectation, predict accepted tokens, watch for hangs
  always @(posedge clk) begin
    if (!rst) begin
      if (code_ch.valid && code_ch.ready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, code_ch.payload);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          if (field_differs("code_valid", want.code_valid, code_ch.payload.code_valid) |
              field_differs("code_type", want.code_type, code_ch.payload.code_type) |
              field_differs("bit_size", want.bit_size, code_ch.payload.bit_size) |
              field_differs("prefix_bits", want.prefix_bits, code_ch.payload.prefix_bits) |
              field_differs("prefix_count", want.prefix_count, code_ch.payload.prefix_count) |
              field_differs("byte_value", want.byte_value, code_ch.payload.byte_value) |
              field_differs("has_byte", want.has_byte, code_ch.payload.has_byte))
            errors++;
        end
        codes_seen++;
      end
      if (tok_ch.valid && tok_ch.ready) begin
        note = typed_notes.pop_front();
        expected_codes.push_back(note.known ? note.code : encode_token(tok_ch.payload));
      end
      if ((tok_ch.valid && tok_ch.ready) || (code_ch.valid && code_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int gap;
    int calm_left;
    rst            <= 1'b1;
    tok_ch.valid   <= 1'b0;
    tok_ch.payload <= '0;
    tokens_sent  = 0;
    codes_seen   = 0;
    errors       = 0;
    idle_cycles  = 0;
    hold_request = 1'b0;
    hold_active  = 1'b0;
    calm_left    = 0;

    // Directed table: literals, class boundaries, invalid combinations
    add_row(make_tok(8'hA5, 0, 5), 1,
            code_t'{1'b1, CT_LITERAL, SIZE_LITERAL, PREFIX_LITERAL, 5'd1, 8'hA5, 1'b1});
    add_row(make_tok(8'h00, 0, 0), 1,
            code_t'{1'b1, CT_LITERAL, SIZE_LITERAL, PREFIX_LITERAL, 5'd1, 8'h00, 1'b1});
    add_row(make_tok(8'hFF, 32767, 0), 1,
            code_t'{1'b1, CT_LITERAL, SIZE_LITERAL, PREFIX_LITERAL, 5'd1, 8'hFF, 1'b1});
    add_row(make_tok(8'h5A, -32768, 0), 1,
            code_t'{1'b1, CT_LITERAL, SIZE_LITERAL, PREFIX_LITERAL, 5'd1, 8'h5A, 1'b1});
    add_row(make_tok(8'h11, -1, 1), 1,
            code_t'{1'b1, CT_LEN1, SIZE_LEN1, 32'h1C00_0000, 5'd6, 8'h00, 1'b0});
    add_row(make_tok(8'h22, -8, 1), 1,
            code_t'{1'b1, CT_LEN1, SIZE_LEN1, 32'h0000_0000, 5'd6, 8'h00, 1'b0});
    add_row(make_tok(8'h33, -9, 1), 1, NO_CODE);
    add_row(make_tok(8'h44, 1, 1), 1, NO_CODE);
    add_row(make_tok(8'h55, -1, 2), 1,
            code_t'{1'b1, CT_LEN2, SIZE_LEN2, PREFIX_LEN2, 5'd3, 8'hFF, 1'b1});
    add_row(make_tok(8'h66, -256, 2), 1,
            code_t'{1'b1, CT_LEN2, SIZE_LEN2, PREFIX_LEN2, 5'd3, 8'h00, 1'b1});
    add_row(make_tok(8'h77, -257, 2), 1, NO_CODE);
    add_row(make_tok(8'h88, -256, 3), 1,
            code_t'{1'b1, CT_LEN3_NEAR, SIZE_LEN3_NEAR, PREFIX_LEN3, 5'd4, 8'h00, 1'b1});
    add_row(make_tok(8'h99, -257, 3), 1,
            code_t'{1'b1, CT_LEN3_FAR, SIZE_LEN3_FAR, 32'h5F00_0000, 5'd8, 8'hFF, 1'b1});
    add_row(make_tok(8'hAA, -4352, 3), 1,
            code_t'{1'b1, CT_LEN3_FAR, SIZE_LEN3_FAR, 32'h5000_0000, 5'd8, 8'h00, 1'b1});
    add_row(make_tok(8'hBB, -4353, 3), 1, NO_CODE);
    add_row(make_tok(8'hCC, -1, 4), 0, NO_CODE);
    add_row(make_tok(8'hDD, -256, 255), 0, NO_CODE);
    add_row(make_tok(8'hEE, -4352, 255), 0, NO_CODE);
    add_row(make_tok(8'h01, -4352, 4), 0, NO_CODE);
    add_row(make_tok(8'h02, -257, 100), 0, NO_CODE);
    add_row(make_tok(8'h03, -1, 256), 1, NO_CODE);
    add_row(make_tok(8'h04, -32768, 511), 1, NO_CODE);
    add_row(make_tok(8'h05, 32767, 5), 1, NO_CODE);
    add_row(make_tok(8'h3C, 0, 1), 0, NO_CODE);

    // Hold reset, then release
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      drive_token(directed_rows[i].tok, directed_rows[i].known, directed_rows[i].code);
      idle_sender(pick_gap());
    end
    wait_drained();

    // Random tokens, with one long receiver hold-off and one full drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) begin
        tok_ch.valid <= 1'b0;
        hold_request = 1'b1;
        while (!hold_active) @(posedge clk);
        calm_left = 20;
      end
      if (n == 700) wait_drained();
      drive_token(random_token(), 1'b0, NO_CODE);
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_left = $urandom_range(20, 60);
      end else begin
        gap = pick_gap();
        idle_sender(gap);
      end
    end

    // Drain and let trailing results surface
    wait_drained();
    tok_ch.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
